// ===== rtl/four_corner_projection_matrix_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four corner projection matrix
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_CORNER_PROJECTION_MATRIX_MACROS_SVH
`define FOUR_CORNER_PROJECTION_MATRIX_MACROS_SVH

// Same-cycle implication
`define FCPM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcpm assertion failed");

// Next-cycle implication
`define FCPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcpm assertion failed");

`endif

// ===== rtl/fcpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpm_pkg
// Constants, types and helpers shared by the projection matrix pipeline.
// ----------------------------------------------------------------------------
package fcpm_pkg;

	localparam int FCPM_COORD_BITS = 10;
	localparam int FCPM_FRAC_BITS  = 24;
	localparam int FCPM_TERM_W     = 40;
	localparam int FCPM_OUT_W      = 32;
	localparam int FCPM_LANES      = 9;
	localparam int FCPM_ROWS       = 3;

	localparam logic [63:0] FCPM_TERM_MAX = 64'd549755813887;

	// Control that travels alongside each transaction
	typedef struct packed {
		logic valid;
		logic degen;
	} ctl_t;

	// Saturate a sign-extended value to the 32-bit output range
	function automatic logic signed [FCPM_OUT_W-1:0] sat_out(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi)
			return hi[FCPM_OUT_W-1:0];
		else if (v < lo)
			return lo[FCPM_OUT_W-1:0];
		else
			return v[FCPM_OUT_W-1:0];
	endfunction

endpackage

// ===== rtl/fcpm_front.sv =====
// ----------------------------------------------------------------------------
// fcpm_front
// Four-stage front end: differences, products, determinants and numerators,
// then sign/magnitude split into divider operands for nine lanes.
// ----------------------------------------------------------------------------
module fcpm_front #(
	parameter int COORD_BITS = fcpm_pkg::FCPM_COORD_BITS,
	parameter int FRAC_BITS  = fcpm_pkg::FCPM_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  go,
	input  logic [COORD_BITS-1:0]                 a_col,
	input  logic [COORD_BITS-1:0]                 a_row,
	input  logic [COORD_BITS-1:0]                 b_col,
	input  logic [COORD_BITS-1:0]                 b_row,
	input  logic [COORD_BITS-1:0]                 c_col,
	input  logic [COORD_BITS-1:0]                 c_row,
	input  logic [COORD_BITS-1:0]                 d_col,
	input  logic [COORD_BITS-1:0]                 d_row,
	output logic [2*COORD_BITS+FRAC_BITS+1:0]     dvd_s4 [fcpm_pkg::FCPM_LANES],
	output logic [2*COORD_BITS+3:0]               dvs_s4 [fcpm_pkg::FCPM_ROWS],
	output logic                                  neg_s4 [fcpm_pkg::FCPM_LANES],
	output fcpm_pkg::ctl_t                        ctl_s4
);
	import fcpm_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int DW  = CB + 1;
	localparam int PW  = 2 * CB + 2;
	localparam int DSW = 2 * CB + 4;
	localparam int NSW = 2 * CB + 1;
	localparam int NVW = 2 * CB + FRAC_BITS + 2;

	// Stage 1: coordinates and differences
	logic [CB-1:0] x1_s1, x2_s1, x3_s1, x4_s1, y1_s1, y2_s1, y3_s1, y4_s1;
	logic signed [DW-1:0] e12_s1, e24_s1, e41_s1, f43_s1, f14_s1, f31_s1;
	logic signed [DW-1:0] g34_s1, g42_s1, g23_s1, n01_s1, n10_s1, n20_s1, n21_s1;
	logic valid_s1;

	function automatic logic signed [CB:0] sdiff(input logic [CB-1:0] p, input logic [CB-1:0] m);
		return $signed({1'b0, p}) - $signed({1'b0, m});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= go;
	end

	always_ff @(posedge clk) begin
		x1_s1  <= a_col;
		y1_s1  <= a_row;
		x2_s1  <= b_col;
		y2_s1  <= b_row;
		x3_s1  <= c_col;
		y3_s1  <= c_row;
		x4_s1  <= d_col;
		y4_s1  <= d_row;
		e12_s1 <= sdiff(a_row, b_row);
		e24_s1 <= sdiff(b_row, d_row);
		e41_s1 <= sdiff(d_row, a_row);
		f43_s1 <= sdiff(d_col, c_col);
		f14_s1 <= sdiff(a_col, d_col);
		f31_s1 <= sdiff(c_col, a_col);
		g34_s1 <= sdiff(c_col, d_col);
		g42_s1 <= sdiff(d_col, b_col);
		g23_s1 <= sdiff(b_col, c_col);
		n01_s1 <= sdiff(b_col, a_col);
		n10_s1 <= sdiff(a_row, c_row);
		n20_s1 <= sdiff(b_row, c_row);
		n21_s1 <= sdiff(c_col, b_col);
	end

	// Stage 2: determinant partial products and numerator products
	logic signed [PW-1:0] p1a_s2, p1b_s2, p1c_s2, p2a_s2, p2b_s2, p2c_s2;
	logic signed [PW-1:0] p3a_s2, p3b_s2, p3c_s2;
	logic [2*CB-1:0] u12_s2, u21_s2, u13_s2, u31_s2, u23_s2, u32_s2;
	logic signed [DW-1:0] n00_s2, n01_s2, n10_s2, n11_s2, n20_s2, n21_s2;
	logic valid_s2;

	function automatic logic signed [2*CB+1:0] smul(input logic signed [CB:0] d,
		input logic [CB-1:0] c);
		logic signed [CB:0] cs;
		cs = $signed({1'b0, c});
		return d * cs;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		p1a_s2 <= smul(e12_s1, x4_s1);
		p1b_s2 <= smul(e24_s1, x1_s1);
		p1c_s2 <= smul(e41_s1, x2_s1);
		p2a_s2 <= smul(f43_s1, y1_s1);
		p2b_s2 <= smul(f14_s1, y3_s1);
		p2c_s2 <= smul(f31_s1, y4_s1);
		p3a_s2 <= smul(g34_s1, y2_s1);
		p3b_s2 <= smul(g42_s1, y3_s1);
		p3c_s2 <= smul(g23_s1, y4_s1);
		u12_s2 <= x1_s1 * y2_s1;
		u21_s2 <= x2_s1 * y1_s1;
		u13_s2 <= x1_s1 * y3_s1;
		u31_s2 <= x3_s1 * y1_s1;
		u23_s2 <= x2_s1 * y3_s1;
		u32_s2 <= x3_s1 * y2_s1;
		n00_s2 <= e12_s1;
		n01_s2 <= n01_s1;
		n10_s2 <= n10_s1;
		n11_s2 <= f31_s1;
		n20_s2 <= n20_s1;
		n21_s2 <= n21_s1;
	end

	// Stage 3: determinants and lane numerators
	logic signed [DSW-1:0] det_s3 [FCPM_ROWS];
	logic signed [NSW-1:0] num_s3 [FCPM_LANES];
	logic valid_s3;

	function automatic logic signed [2*CB+3:0] sum3(input logic signed [2*CB+1:0] a,
		input logic signed [2*CB+1:0] b, input logic signed [2*CB+1:0] c);
		return DSW'(a) + DSW'(b) + DSW'(c);
	endfunction

	function automatic logic signed [2*CB:0] udiff(input logic [2*CB-1:0] p,
		input logic [2*CB-1:0] m);
		return $signed({1'b0, p}) - $signed({1'b0, m});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		det_s3[0] <= sum3(p1a_s2, p1b_s2, p1c_s2);
		det_s3[1] <= sum3(p2a_s2, p2b_s2, p2c_s2);
		det_s3[2] <= sum3(p3a_s2, p3b_s2, p3c_s2);
		num_s3[0] <= NSW'(n00_s2);
		num_s3[1] <= NSW'(n01_s2);
		num_s3[2] <= udiff(u12_s2, u21_s2);
		num_s3[3] <= NSW'(n10_s2);
		num_s3[4] <= NSW'(n11_s2);
		num_s3[5] <= udiff(u13_s2, u31_s2);
		num_s3[6] <= NSW'(n20_s2);
		num_s3[7] <= NSW'(n21_s2);
		num_s3[8] <= udiff(u23_s2, u32_s2);
	end

	// Stage 4: split sign and magnitude, build rounded dividends
	logic [DSW-1:0] dmag [FCPM_ROWS];
	logic [NSW-1:0] nmag [FCPM_LANES];
	logic           degen;

	always_comb begin
		for (int r = 0; r < FCPM_ROWS; r++)
			dmag[r] = det_s3[r][DSW-1] ? DSW'(-det_s3[r]) : DSW'(det_s3[r]);
		for (int k = 0; k < FCPM_LANES; k++)
			nmag[k] = num_s3[k][NSW-1] ? NSW'(-num_s3[k]) : NSW'(num_s3[k]);
		degen = (det_s3[0] == '0) || (det_s3[1] == '0) || (det_s3[2] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s4 <= '0;
		else begin
			ctl_s4.valid <= valid_s3;
			ctl_s4.degen <= degen;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < FCPM_ROWS; r++)
			dvs_s4[r] <= {dmag[r][DSW-2:0], 1'b0};
		for (int k = 0; k < FCPM_LANES; k++) begin
			dvd_s4[k] <= (NVW'(nmag[k][NSW-2:0]) << (FRAC_BITS + 1)) + NVW'(dmag[k / 3]);
			neg_s4[k] <= num_s3[k][NSW-1] ^ det_s3[k / 3][DSW-1];
		end
	end

endmodule

// ===== rtl/fcpm_div.sv =====
// ----------------------------------------------------------------------------
// fcpm_div
// Pipelined restoring divider, one quotient bit per stage, with a sign tag
// carried alongside.
// ----------------------------------------------------------------------------
module fcpm_div #(
	parameter int NVW = 46,
	parameter int DVW = 24
) (
	input  logic           clk,
	input  logic [NVW-1:0] dvd,
	input  logic [DVW-1:0] dvs,
	input  logic           neg,
	output logic [NVW-1:0] quo,
	output logic           quo_neg
);
	import fcpm_pkg::*;

	logic [DVW-1:0] rem_s [NVW];
	logic [NVW-1:0] dvd_s [NVW];
	logic [NVW-1:0] quo_s [NVW];
	logic [DVW-1:0] dvs_s [NVW];
	logic           neg_s [NVW];

	for (genvar k = 0; k < NVW; k++) begin : g_stage
		logic [DVW-1:0] rem_in;
		logic [NVW-1:0] dvd_in;
		logic [NVW-1:0] quo_in;
		logic [DVW-1:0] dvs_in;
		logic           neg_in;
		logic [DVW:0]   trial;
		logic           fit;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign dvd_in = dvd;
			assign quo_in = '0;
			assign dvs_in = dvs;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign quo_in = quo_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign neg_in = neg_s[k-1];
		end

		// Shift in the next dividend bit and try the subtract
		assign trial = {rem_in, dvd_in[NVW-1-k]};
		assign fit   = trial >= {1'b0, dvs_in};

		always_ff @(posedge clk) begin
			rem_s[k] <= fit ? DVW'(trial - {1'b0, dvs_in}) : trial[DVW-1:0];
			quo_s[k] <= {quo_in[NVW-2:0], fit};
			dvd_s[k] <= dvd_in;
			dvs_s[k] <= dvs_in;
			neg_s[k] <= neg_in;
		end
	end

	assign quo     = quo_s[NVW-1];
	assign quo_neg = neg_s[NVW-1];

endmodule

// ===== rtl/fcpm_back.sv =====
// ----------------------------------------------------------------------------
// fcpm_back
// Three-stage back end: sign and 40-bit term clamp, third-row sum with
// first- and second-row saturation, then output saturation and degenerate zeroing.
// ----------------------------------------------------------------------------
module fcpm_back #(
	parameter int NVW = 46
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [NVW-1:0]                         quo [fcpm_pkg::FCPM_LANES],
	input  logic                                   neg [fcpm_pkg::FCPM_LANES],
	input  fcpm_pkg::ctl_t                         ctl,
	output logic signed [fcpm_pkg::FCPM_OUT_W-1:0] coef [fcpm_pkg::FCPM_LANES],
	output logic                                   degenerate,
	output logic                                   done
);
	import fcpm_pkg::*;

	localparam int EW = (NVW > FCPM_TERM_W) ? NVW : FCPM_TERM_W;
	localparam int SW = FCPM_TERM_W + 2;

	// Stage 1: apply sign and clamp to the term range
	logic signed [FCPM_TERM_W-1:0] term_s1 [FCPM_LANES];
	ctl_t                          ctl_s1;
	logic [EW-1:0]                 qext [FCPM_LANES];
	logic                          big  [FCPM_LANES];
	logic signed [FCPM_TERM_W-1:0] tmax;

	always_comb begin
		tmax = FCPM_TERM_MAX[FCPM_TERM_W-1:0];
		for (int k = 0; k < FCPM_LANES; k++) begin
			qext[k] = EW'(quo[k]);
			big[k]  = qext[k] > EW'(FCPM_TERM_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s1 <= '0;
		else
			ctl_s1 <= ctl;
	end

	// Clamp to the most negative term value with the bitwise inverse of the maximum
	always_ff @(posedge clk) begin
		for (int k = 0; k < FCPM_LANES; k++) begin
			if (big[k])
				term_s1[k] <= neg[k] ? ~tmax : tmax;
			else
				term_s1[k] <= neg[k] ? -FCPM_TERM_W'(qext[k]) : FCPM_TERM_W'(qext[k]);
		end
	end

	// Stage 2: saturate rows 0 and 1, sum row 2 exactly
	logic signed [FCPM_OUT_W-1:0] rows_s2 [6];
	logic signed [SW-1:0]         sum_s2  [3];
	ctl_t                         ctl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s2 <= '0;
		else
			ctl_s2 <= ctl_s1;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++)
			rows_s2[k] <= sat_out(64'(term_s1[k]));
		for (int c = 0; c < 3; c++)
			sum_s2[c] <= SW'(term_s1[c]) + SW'(term_s1[3+c]) + SW'(term_s1[6+c]);
	end

	// Stage 3: saturate row 2, zero everything on degenerate corners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done       <= 1'b0;
			degenerate <= 1'b0;
		end else begin
			done       <= ctl_s2.valid;
			degenerate <= ctl_s2.degen;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++)
			coef[k] <= ctl_s2.degen ? '0 : rows_s2[k];
		for (int c = 0; c < 3; c++)
			coef[6+c] <= ctl_s2.degen ? '0 : sat_out(64'(sum_s2[c]));
	end

endmodule

// ===== rtl/four_corner_projection_matrix.sv =====
// ----------------------------------------------------------------------------
// four_corner_projection_matrix
// Fully pipelined 3x3 projection matrix from four screen corner points,
// signed Q8.24 coefficients with saturation and a degenerate flag.
// ----------------------------------------------------------------------------
//  channel   strobe   payload
//  command   start    a_col a_row b_col b_row c_col c_row d_col d_row
//  result    done     m00..m22 degenerate
//
//  Four front stages, one restoring divider stage per quotient bit and
//  three back stages. A new command is taken every cycle; busy stays low.
//  Reset clears only the control chain (valid and degenerate flags); no clearing pass is needed.
//  The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module four_corner_projection_matrix #(
	parameter int COORD_BITS = fcpm_pkg::FCPM_COORD_BITS,
	parameter int FRAC_BITS  = fcpm_pkg::FCPM_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [COORD_BITS-1:0]                  a_col,
	input  logic [COORD_BITS-1:0]                  a_row,
	input  logic [COORD_BITS-1:0]                  b_col,
	input  logic [COORD_BITS-1:0]                  b_row,
	input  logic [COORD_BITS-1:0]                  c_col,
	input  logic [COORD_BITS-1:0]                  c_row,
	input  logic [COORD_BITS-1:0]                  d_col,
	input  logic [COORD_BITS-1:0]                  d_row,
	output logic                                   done,
	output logic signed [fcpm_pkg::FCPM_OUT_W-1:0] m00,
	output logic signed [fcpm_pkg::FCPM_OUT_W-1:0] m01,
	output logic signed [fcpm_pkg::FCPM_OUT_W-1:0] m02,
	output logic signed [fcpm_pkg::FCPM_OUT_W-1:0] m10,
	output logic signed [fcpm_pkg::FCPM_OUT_W-1:0] m11,
	output logic signed [fcpm_pkg::FCPM_OUT_W-1:0] m12,
	output logic signed [fcpm_pkg::FCPM_OUT_W-1:0] m20,
	output logic signed [fcpm_pkg::FCPM_OUT_W-1:0] m21,
	output logic signed [fcpm_pkg::FCPM_OUT_W-1:0] m22,
	output logic                                   degenerate
);
	import fcpm_pkg::*;

	`include "four_corner_projection_matrix_macros.svh"

	localparam int NVW = 2 * COORD_BITS + FRAC_BITS + 2;
	localparam int DVW = 2 * COORD_BITS + 4;
	localparam int LAT = NVW + 7;

	// Pipeline never backs up
	assign busy = 1'b0;

	logic go;
	assign go = start && !busy;

	// Front end
	logic [NVW-1:0] dvd_s4 [FCPM_LANES];
	logic [DVW-1:0] dvs_s4 [FCPM_ROWS];
	logic           neg_s4 [FCPM_LANES];
	ctl_t           ctl_s4;

	fcpm_front #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.a_col (a_col),
		.a_row (a_row),
		.b_col (b_col),
		.b_row (b_row),
		.c_col (c_col),
		.c_row (c_row),
		.d_col (d_col),
		.d_row (d_row),
		.dvd_s4(dvd_s4),
		.dvs_s4(dvs_s4),
		.neg_s4(neg_s4),
		.ctl_s4(ctl_s4)
	);

	// Nine divider lanes
	logic [NVW-1:0] quo     [FCPM_LANES];
	logic           quo_neg [FCPM_LANES];

	for (genvar k = 0; k < FCPM_LANES; k++) begin : g_lane
		fcpm_div #(
			.NVW(NVW),
			.DVW(DVW)
		) u_div (
			.clk    (clk),
			.dvd    (dvd_s4[k]),
			.dvs    (dvs_s4[k / 3]),
			.neg    (neg_s4[k]),
			.quo    (quo[k]),
			.quo_neg(quo_neg[k])
		);
	end

	// Carry control alongside the divider stages
	ctl_t ctl_dly_q [NVW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NVW; i++)
				ctl_dly_q[i] <= '0;
		end else begin
			ctl_dly_q[0] <= ctl_s4;
			for (int i = 1; i < NVW; i++)
				ctl_dly_q[i] <= ctl_dly_q[i-1];
		end
	end

	// Back end
	logic signed [FCPM_OUT_W-1:0] coef [FCPM_LANES];

	fcpm_back #(
		.NVW(NVW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.quo       (quo),
		.neg       (quo_neg),
		.ctl       (ctl_dly_q[NVW-1]),
		.coef      (coef),
		.degenerate(degenerate),
		.done      (done)
	);

	assign m00 = coef[0];
	assign m01 = coef[1];
	assign m02 = coef[2];
	assign m10 = coef[3];
	assign m11 = coef[4];
	assign m12 = coef[5];
	assign m20 = coef[6];
	assign m21 = coef[7];
	assign m22 = coef[8];

	// Flag an all-zero coefficient set
	logic coef_zero;
	assign coef_zero = (m00 == '0) && (m01 == '0) && (m02 == '0) && (m10 == '0) &&
		(m11 == '0) && (m12 == '0) && (m20 == '0) && (m21 == '0) && (m22 == '0);

	// Every accepted transaction comes out after the fixed latency
	`FCPM_ASSERT_NEXT(a_lat_fwd, clk, arst_n, go, ##(LAT-1) done)
	// No result without a transaction accepted the matching latency earlier
	`FCPM_ASSERT_IMPLIES(a_lat_back, clk, arst_n, done, $past(go, LAT))
	// Degenerate results carry all-zero coefficients
	`FCPM_ASSERT_IMPLIES(a_degen_zero, clk, arst_n, done && degenerate, coef_zero)

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Projection matrix block testbench
// Drives corner sets through the start/busy command port, predicts each
// coefficient set in fixed point, and checks every done strobe in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcpm_pkg::*;

	localparam int CW = FCPM_COORD_BITS;
	localparam int FB = FCPM_FRAC_BITS;
	localparam int LATENCY = 2 * CW + FB + 9;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic [FCPM_OUT_W-1:0] m [9];
		logic                  degen;
	} matrix_t;

	// Quotient num * 2^FB / den, rounded away from zero on ties, held to 40 bits
	function automatic longint fixed_quotient(longint num, longint den);
		bit neg;
		longint un, ud, q;
		neg = (num < 0) != (den < 0);
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		q = ((un << (FB + 1)) + ud) / (ud << 1);
		if (q > longint'(FCPM_TERM_MAX))
			return neg ? -longint'(FCPM_TERM_MAX) - 1 : longint'(FCPM_TERM_MAX);
		return neg ? -q : q;
	endfunction

	function automatic logic [FCPM_OUT_W-1:0] clamp_out(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[FCPM_OUT_W-1:0];
	endfunction

	function automatic matrix_t projection_of(logic [CW-1:0] c [8]);
		matrix_t r;
		longint x1, y1, x2, y2, x3, y3, x4, y4, d1, d2, d3;
		longint t0 [3], t1 [3], t2 [3];
		x1 = c[0]; y1 = c[1]; x2 = c[2]; y2 = c[3];
		x3 = c[4]; y3 = c[5]; x4 = c[6]; y4 = c[7];
		d1 = x4 * (y1 - y2) + x1 * (y2 - y4) + x2 * (y4 - y1);
		d2 = -x3 * y1 + x4 * y1 + x1 * y3 - x4 * y3 - x1 * y4 + x3 * y4;
		d3 = x3 * y2 - x4 * y2 - x2 * y3 + x4 * y3 + x2 * y4 - x3 * y4;
		r.degen = (d1 == 0 || d2 == 0 || d3 == 0);
		for (int i = 0; i < 9; i++)
			r.m[i] = '0;
		if (r.degen)
			return r;
		t0[0] = fixed_quotient(y1 - y2, d1);
		t0[1] = fixed_quotient(x2 - x1, d1);
		t0[2] = fixed_quotient(x1 * y2 - x2 * y1, d1);
		t1[0] = fixed_quotient(y1 - y3, d2);
		t1[1] = fixed_quotient(x3 - x1, d2);
		t1[2] = fixed_quotient(x1 * y3 - x3 * y1, d2);
		t2[0] = fixed_quotient(y2 - y3, d3);
		t2[1] = fixed_quotient(x3 - x2, d3);
		t2[2] = fixed_quotient(x2 * y3 - x3 * y2, d3);
		for (int i = 0; i < 3; i++) begin
			r.m[i]     = clamp_out(t0[i]);
			r.m[3 + i] = clamp_out(t1[i]);
			r.m[6 + i] = clamp_out(t0[i] + t1[i] + t2[i]);
		end
		return r;
	endfunction

	class matrix_scoreboard;
		matrix_t pending [$];
		int      mismatches;

		function void note_command(logic [CW-1:0] c [8]);
			pending.push_back(projection_of(c));
		endfunction

		function void check_result(matrix_t got);
			matrix_t want;
			bit bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with no transaction pending");
				return;
			end
			want = pending.pop_front();
			bad = (want.degen !== got.degen);
			for (int i = 0; i < 9; i++)
				if (want.m[i] !== got.m[i])
					bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: degenerate exp %0b got %0b", want.degen, got.degen);
					for (int i = 0; i < 9; i++)
						$display("  m%0d%0d exp %h got %h", i / 3, i % 3, want.m[i], got.m[i]);
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done, degenerate;
	logic [CW-1:0] a_col = '0, a_row = '0, b_col = '0, b_row = '0;
	logic [CW-1:0] c_col = '0, c_row = '0, d_col = '0, d_row = '0;
	logic signed [FCPM_OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	matrix_scoreboard sb = new();
	longint cycles = 0;
	int idle_left = 0;
	bit idling_on = 1;

	four_corner_projection_matrix dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Check each result and bound the run
	always @(posedge clk) begin
		matrix_t got;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("four_corner_projection_matrix regression: fail");
			$finish;
		end
		if (arst_n && done === 1'b1) begin
			got.degen = degenerate;
			got.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			sb.check_result(got);
		end
	end

	// Drive one corner set and hold it until the block takes it; start stays
	// high into the next transaction unless an idle burst drops it
	task automatic send_corners(logic [CW-1:0] c [8]);
		if (idling_on && idle_left == 0 && $urandom_range(0, 5) == 0)
			idle_left = $urandom_range(1, 12);
		while (idle_left > 0) begin
			@(negedge clk);
			start <= 0;
			idle_left--;
		end
		@(negedge clk);
		{a_col, a_row, b_col, b_row} = {c[0], c[1], c[2], c[3]};
		{c_col, c_row, d_col, d_row} = {c[4], c[5], c[6], c[7]};
		start <= 1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_command(c);
	endtask

	function automatic logic [CW-1:0] wobble(int base, int spread);
		int v;
		v = base + $urandom_range(0, 2 * spread) - spread;
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return CW'(v);
	endfunction

	initial begin
		logic [CW-1:0] c [8];
		int cx0, cy0, cx1, cy1, sz;
		repeat (10) @(negedge clk);
		arst_n = 1;

		// Directed: extremes, degenerate shapes, tiny and full rectangles
		c = '{0, 0, 0, 0, 0, 0, 0, 0};               send_corners(c);
		c = '{1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023}; send_corners(c);
		c = '{0, 0, 0, 1023, 1023, 0, 1023, 1023};   send_corners(c);
		c = '{100, 100, 100, 200, 200, 100, 200, 200}; send_corners(c);
		c = '{10, 10, 10, 11, 11, 10, 11, 11};       send_corners(c);
		c = '{0, 0, 0, 1, 1, 0, 1, 1};               send_corners(c);
		c = '{0, 0, 1, 1023, 1023, 1, 1022, 1022};   send_corners(c);
		c = '{1023, 0, 0, 0, 0, 1023, 1023, 1023};   send_corners(c);
		c = '{5, 5, 10, 10, 20, 20, 30, 30};         send_corners(c);
		c = '{0, 0, 0, 1, 1023, 0, 1023, 1023};      send_corners(c);
		c = '{0, 0, 1, 1, 1023, 1, 0, 1023};         send_corners(c);
		c = '{512, 0, 0, 512, 1023, 512, 512, 1023}; send_corners(c);
		c = '{200, 150, 180, 800, 900, 120, 950, 850}; send_corners(c);
		c = '{1023, 1023, 1023, 0, 0, 1023, 0, 0};   send_corners(c);
		c = '{0, 1023, 1023, 0, 0, 0, 1023, 1023};   send_corners(c);

		// Random: mostly plausible quadrilaterals, some tiny, some pure noise
		for (int n = 0; n < 1600; n++) begin
			if (n == 1400)
				idling_on = 0;
			case ($urandom_range(0, 9))
				0, 1: begin
					for (int i = 0; i < 8; i++)
						c[i] = CW'($urandom);
				end
				2: begin
					cx0 = $urandom_range(0, 1020); cy0 = $urandom_range(0, 1020);
					for (int i = 0; i < 8; i++)
						c[i] = wobble((i % 2) ? cy0 : cx0, 3);
				end
				default: begin
					sz = $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(2, 600);
					cx0 = $urandom_range(0, 1023 - sz / 2); cy0 = $urandom_range(0, 1023 - sz / 2);
					cx1 = cx0 + sz; cy1 = cy0 + sz;
					c = '{wobble(cx0, 40), wobble(cy0, 40), wobble(cx0, 40), wobble(cy1, 40),
						wobble(cx1, 40), wobble(cy0, 40), wobble(cx1, 40), wobble(cy1, 40)};
				end
			endcase
			send_corners(c);
		end

		// Release the command port
		@(negedge clk);
		start <= 0;

		// Drain
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("four_corner_projection_matrix regression: pass");
		else
			$display("four_corner_projection_matrix regression: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fcpm_pkg.sv
rtl/fcpm_front.sv
rtl/fcpm_div.sv
rtl/fcpm_back.sv
rtl/four_corner_projection_matrix.sv
tb/tb.sv
